// ===== rtl/bounded_stack_with_search_top_defines.svh =====
// Assertion macros for the bounded stack with search block.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef BOUNDED_STACK_WITH_SEARCH_TOP_DEFINES_SVH
`define BOUNDED_STACK_WITH_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BSTK_ASSERT_NOW(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BSTK_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/bstk_pkg.sv =====
// Shared constants, codes and request type for the bounded stack with search.
// No dependencies.
package bstk_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int POS_W   = 4;
    localparam int FIDX_W  = 4;
    localparam int OP_W    = 2;
    localparam int ST_W    = 2;

    // request queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd3;

    localparam logic [ST_W-1:0] ST_OK          = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL        = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY_RANGE = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND   = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] value;
        logic [POS_W-1:0]  position;
    } cmd_t;

endpackage

// ===== rtl/bstk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bstk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bstk_front.sv =====
// Front end: accepts requests and holds them in a short queue for the back end.
// Depends on bstk_pkg.
module bstk_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bstk_pkg::OP_W-1:0]     operation,
    input  logic [bstk_pkg::DATA_W-1:0]   value,
    input  logic [bstk_pkg::POS_W-1:0]    position,
    output logic                          cmd_valid,
    output bstk_pkg::cmd_t                cmd,
    input  logic                          cmd_take
);
    import bstk_pkg::*;

    cmd_t              q_cmd_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] qcnt_reg, qcnt_next;
    logic              push_q;
    logic              pop_q;
    cmd_t              in_cmd;

    assign in_stall  = (qcnt_reg == QCNT_W'(QDEPTH));
    assign cmd_valid = (qcnt_reg != '0);
    assign cmd       = q_cmd_reg[rptr_reg];
    assign push_q    = in_valid && !in_stall;
    assign pop_q     = cmd_take && cmd_valid;

    always_comb
    begin
        in_cmd.op       = operation;
        in_cmd.value    = value;
        in_cmd.position = position;
    end

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        qcnt_next = qcnt_reg;
        if (push_q)
        begin
            wptr_next = (wptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop_q)
        begin
            rptr_next = (rptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push_q && !pop_q)
        begin
            qcnt_next = qcnt_reg + 1'b1;
        end
        else if (pop_q && !push_q)
        begin
            qcnt_next = qcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            qcnt_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            qcnt_reg <= qcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_q)
        begin
            q_cmd_reg[wptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== rtl/bstk_back.sv =====
// Back end: executes queued requests against the entry RAM and fill count,
// and holds each result in an output register. Depends on bstk_pkg, bstk_ram.
module bstk_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  bstk_pkg::cmd_t                cmd,
    output logic                          cmd_take,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bstk_pkg::ST_W-1:0]     status,
    output logic [bstk_pkg::DATA_W-1:0]   read_value,
    output logic [bstk_pkg::FIDX_W-1:0]   found_index,
    output logic [bstk_pkg::CNT_W-1:0]    count,
    output logic                          is_empty
);
    import bstk_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]  scan_reg, scan_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic              res_valid_reg, res_valid_next;
    logic [ST_W-1:0]   status_reg, status_next;
    logic [DATA_W-1:0] read_value_reg, read_value_next;
    logic [FIDX_W-1:0] found_index_reg, found_index_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              empty_reg, empty_next;

    logic              slot_free;
    logic              finish;
    logic [ST_W-1:0]   fin_status;
    logic [DATA_W-1:0] fin_rd;
    logic [FIDX_W-1:0] fin_fidx;
    logic              ram_we;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    bstk_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[IDX_W-1:0]),
        .wdata (cmd.value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign slot_free = !res_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        scan_next  = scan_reg;
        key_next   = key_reg;
        cmd_take   = 1'b0;
        finish     = 1'b0;
        fin_status = ST_OK;
        fin_rd     = '0;
        fin_fidx   = '0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    cmd_take = 1'b1;
                    case (cmd.op)
                        OP_PUSH:
                        begin
                            finish = 1'b1;
                            if (fill_reg == CNT_W'(DEPTH))
                            begin
                                fin_status = ST_FULL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            finish = 1'b1;
                            if (fill_reg == '0)
                            begin
                                fin_status = ST_EMPTY_RANGE;
                            end
                            else
                            begin
                                fill_next = fill_reg - 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            if (CNT_W'(cmd.position) < fill_reg)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = IDX_W'(cmd.position);
                                state_next = S_READ;
                            end
                            else
                            begin
                                finish     = 1'b1;
                                fin_status = ST_EMPTY_RANGE;
                            end
                        end
                        default:
                        begin
                            key_next = cmd.value;
                            if (fill_reg == '0)
                            begin
                                finish     = 1'b1;
                                fin_status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                scan_next  = '0;
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (slot_free)
                begin
                    finish     = 1'b1;
                    fin_rd     = ram_rdata;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                // read data holds while re is low, so a stalled scan just waits
                if (slot_free)
                begin
                    if (ram_rdata == key_reg)
                    begin
                        finish     = 1'b1;
                        fin_fidx   = FIDX_W'(scan_reg);
                        state_next = S_IDLE;
                    end
                    else if (CNT_W'(scan_reg) + 1'b1 == fill_reg)
                    begin
                        finish     = 1'b1;
                        fin_status = ST_NOT_FOUND;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = scan_reg + 1'b1;
                        scan_next = scan_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next   = res_valid_reg;
        status_next      = status_reg;
        read_value_next  = read_value_reg;
        found_index_next = found_index_reg;
        count_next       = count_reg;
        empty_next       = empty_reg;
        if (finish)
        begin
            res_valid_next   = 1'b1;
            status_next      = fin_status;
            read_value_next  = fin_rd;
            found_index_next = fin_fidx;
            count_next       = fill_next;
            empty_next       = (fill_next == '0);
        end
        else if (!out_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg        <= scan_next;
        key_reg         <= key_next;
        status_reg      <= status_next;
        read_value_reg  <= read_value_next;
        found_index_reg <= found_index_next;
        count_reg       <= count_next;
        empty_reg       <= empty_next;
    end

    assign out_valid   = res_valid_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign found_index = found_index_reg;
    assign count       = count_reg;
    assign is_empty    = empty_reg;

endmodule

// ===== rtl/bounded_stack_with_search_top.sv =====
// Top level of the bounded stack with search: front end, request queue, back end.
// Depends on bstk_pkg, bstk_front, bstk_back and the assertion macro header.
//
// Usage:
// - Input channel (in_valid/in_stall) carries one request: operation, value and
//   position. Operations: push, pop, read at position, search for value.
// - Output channel (out_valid/out_stall) returns exactly one result per request,
//   in order: status, read_value, found_index, count and is_empty.
// - Requests enter a two-deep queue; in_stall rises only when the queue is full.
// - Each result is registered in the back end before it is offered. A read first
//   reads the entry RAM at position; a search compares stored entries from the
//   bottom, one by one, and stops at the first match or after the last of up to
//   16 entries (the fill count).
// - Throughput: one push, pop or rejected request per cycle while the receiver
//   does not stall; a read or search holds the back end until it finishes. The
//   single read port of the entry RAM scans one entry per cycle when not stalled.
// - When the receiver stalls, the result register holds its value, the back end
//   stops at the next result, and the queue fills before in_stall is raised.
// - Reset empties the stack and the queue and drops any pending result. Entry
//   storage is not cleared; only entries below the fill count are ever read.
module bounded_stack_with_search_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bstk_pkg::OP_W-1:0]     operation,
    input  logic [bstk_pkg::DATA_W-1:0]   value,
    input  logic [bstk_pkg::POS_W-1:0]    position,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bstk_pkg::ST_W-1:0]     status,
    output logic [bstk_pkg::DATA_W-1:0]   read_value,
    output logic [bstk_pkg::FIDX_W-1:0]   found_index,
    output logic [bstk_pkg::CNT_W-1:0]    count,
    output logic                          is_empty
);
    import bstk_pkg::*;

`include "bounded_stack_with_search_top_defines.svh"

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_take;

    // accept and queue requests
    bstk_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .value     (value),
        .position  (position),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // execute requests and hold results
    bstk_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_take    (cmd_take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .read_value  (read_value),
        .found_index (found_index),
        .count       (count),
        .is_empty    (is_empty)
    );

    // a full queue always presents a request to the back end
    `BSTK_ASSERT_NOW(a_full_queue_visible, in_stall, cmd_valid, "queue full but no request")

    // failed operations carry zero read data and index
    `BSTK_ASSERT_NOW(a_fail_zero_payload, out_valid && (status != ST_OK),
        (read_value == '0) && (found_index == '0), "nonzero payload on failure")

    // consecutive results move the count by at most one
    `BSTK_ASSERT_NEXT(a_count_step, out_valid && !out_stall,
        !out_valid || (count == $past(count)) || (count == $past(count) + 1'b1) ||
        (count == $past(count) - 1'b1), "count jumped")

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for bounded_stack_with_search_top: push, pop, read and search requests.
// Depends on bstk_pkg and the RTL top level; keeps its own shadow stack to predict each result.
module tb_top;
    import bstk_pkg::*;

    localparam int RANDOM_REQS  = 750;
    localparam int LONG_HOLD    = 80;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic              wait_drain;
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] val;
        logic [POS_W-1:0]  pos;
    } stack_req_t;

    typedef struct packed {
        logic [ST_W-1:0]   st;
        logic [DATA_W-1:0] rd;
        logic [FIDX_W-1:0] fidx;
        logic [CNT_W-1:0]  cnt;
        logic              empty;
    } stack_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [OP_W-1:0]     operation = OP_PUSH;
    logic [DATA_W-1:0]   value = '0;
    logic [POS_W-1:0]    position = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [ST_W-1:0]     status;
    logic [DATA_W-1:0]   read_value;
    logic [FIDX_W-1:0]   found_index;
    logic [CNT_W-1:0]    count;
    logic                is_empty;

    logic                hold_off = 1'b0;

    stack_req_t          pending_reqs[$];
    stack_result_t       expected_results[$];
    logic [DATA_W-1:0]   pushed_vals[$];

    // Shadow copy of the stack contents and fill level
    logic [DATA_W-1:0]   stack_words [DEPTH];
    int                  stack_fill = 0;

    int                  n_queued = 0;
    int                  n_accepted = 0;
    int                  n_results = 0;
    int                  n_errors = 0;
    int                  n_drains = 0;
    int                  op_tally [4];
    int                  status_tally [4];
    int                  idle_cycles = 0;

    bounded_stack_with_search_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .value       (value),
        .position    (position),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .read_value  (read_value),
        .found_index (found_index),
        .count       (count),
        .is_empty    (is_empty)
    );

    always #5 clk = ~clk;

    // Hold reset at the start, then release it for good
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Apply one request to the shadow stack and return the result it must produce
    function automatic stack_result_t predict_stack_result(logic [OP_W-1:0] op,
                                                           logic [DATA_W-1:0] val,
                                                           logic [POS_W-1:0] pos);
        stack_result_t res;
        bit            hit;
        res = '0;
        res.st = ST_OK;
        hit = 1'b0;
        case (op)
            OP_PUSH:
            begin
                if (stack_fill >= DEPTH)
                    res.st = ST_FULL;
                else
                begin
                    stack_words[stack_fill] = val;
                    stack_fill++;
                end
            end
            OP_POP:
            begin
                if (stack_fill == 0)
                    res.st = ST_EMPTY_RANGE;
                else
                    stack_fill--;
            end
            OP_READ:
            begin
                if (int'(pos) < stack_fill)
                    res.rd = stack_words[pos];
                else
                    res.st = ST_EMPTY_RANGE;
            end
            default:
            begin
                // Scan from the bottom; the lowest matching index wins
                for (int i = 0; i < stack_fill; i++)
                begin
                    if (!hit && stack_words[i] == val)
                    begin
                        hit = 1'b1;
                        res.fidx = FIDX_W'(i);
                    end
                end
                if (!hit)
                    res.st = ST_NOT_FOUND;
            end
        endcase
        res.cnt = CNT_W'(stack_fill);
        res.empty = (stack_fill == 0);
        return res;
    endfunction

    // Most gaps are zero or short; a few run long. A calm stretch never idles.
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // Mix fresh random words, a tiny pool that makes duplicates, the extremes,
    // and values already pushed so that searches and reads hit
    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3 || (r >= 6 && pushed_vals.size() == 0))
            return $urandom;
        if (r < 5)
            return DATA_W'($urandom_range(0, 5));
        if (r < 6)
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
        return pushed_vals[$urandom_range(0, pushed_vals.size() - 1)];
    endfunction

    task automatic add_req(logic [OP_W-1:0] op, logic [DATA_W-1:0] val, logic [POS_W-1:0] pos);
        stack_req_t req;
        req.wait_drain = 1'b0;
        req.op = op;
        req.val = val;
        req.pos = pos;
        pending_reqs = {pending_reqs, req};
        n_queued++;
        if (op == OP_PUSH)
        begin
            pushed_vals = {pushed_vals, val};
            if (pushed_vals.size() > 32)
                void'(pushed_vals.pop_front());
        end
    endtask

    // Marker: the sender holds off until every outstanding result is back
    task automatic add_pause();
        stack_req_t req;
        req = '0;
        req.wait_drain = 1'b1;
        pending_reqs = {pending_reqs, req};
    endtask

    task automatic add_mixed_req(bit noisy);
        int               r;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        r = $urandom_range(0, 99);
        if (r < 30)
            op = OP_PUSH;
        else if (r < 50)
            op = OP_POP;
        else if (r < 75)
            op = OP_READ;
        else
            op = OP_SEARCH;
        // Bias reads toward the low entries that are most often live
        pos = ($urandom_range(0, 1) != 0) ? POS_W'($urandom_range(0, 7)) : POS_W'($urandom);
        add_req(op, noisy ? DATA_W'($urandom) : pick_value(), pos);
    endtask

    initial
    begin : stimulus
        int seg;
        int len;

        for (int i = 0; i < 4; i++)
        begin
            op_tally[i] = 0;
            status_tally[i] = 0;
        end

        // Directed: empty-stack corners, extreme values, duplicate match, range edges
        add_req(OP_POP,    '0, '0);
        add_req(OP_READ,   '0, '0);
        add_req(OP_SEARCH, '0, '0);
        add_req(OP_PUSH,   '0, '0);
        add_req(OP_PUSH,   '1, '0);
        add_req(OP_PUSH,   '0, '1);
        add_req(OP_SEARCH, '0, '0);
        add_req(OP_SEARCH, '1, '0);
        add_req(OP_SEARCH, 32'h1234_5678, '0);
        add_req(OP_READ,   '1, 4'd0);
        add_req(OP_READ,   '0, 4'd1);
        add_req(OP_READ,   '0, 4'd2);
        add_req(OP_READ,   '0, 4'd3);
        add_req(OP_READ,   '0, 4'd15);
        add_req(OP_POP,    '0, '0);
        add_req(OP_POP,    '0, '0);
        add_req(OP_POP,    '0, '0);
        add_req(OP_POP,    '0, '0);
        add_pause();

        // Open the random part by filling past full, then search deep into a full stack
        for (int i = 0; i < 18; i++)
            add_req(OP_PUSH, pick_value(), '0);
        add_req(OP_SEARCH, pushed_vals[pushed_vals.size() - 3], '0);
        add_req(OP_READ, '0, 4'd15);

        while (n_queued < 18 + RANDOM_REQS)
        begin
            seg = $urandom_range(0, 9);
            if (seg < 3)
            begin
                len = $urandom_range(6, 20);
                for (int i = 0; i < len; i++)
                    if ($urandom_range(0, 5) == 0)
                        add_mixed_req(1'b0);
                    else
                        add_req(OP_PUSH, pick_value(), POS_W'($urandom));
            end
            else if (seg < 5)
            begin
                len = $urandom_range(4, 18);
                for (int i = 0; i < len; i++)
                    if ($urandom_range(0, 4) == 0)
                        add_mixed_req(1'b0);
                    else
                        add_req(OP_POP, DATA_W'($urandom), POS_W'($urandom));
            end
            else
            begin
                len = $urandom_range(10, 30);
                for (int i = 0; i < len; i++)
                    add_mixed_req(seg == 9);
            end
            if ($urandom_range(0, 7) == 0)
                add_pause();
        end

        // Wait for every request to go in, then for every result to come back
        while (rst_n !== 1'b1 || n_accepted < n_queued)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests (push %0d, pop %0d, read %0d, search %0d), %0d drain pauses.",
                 n_accepted, op_tally[OP_PUSH], op_tally[OP_POP], op_tally[OP_READ],
                 op_tally[OP_SEARCH], n_drains);
        $display("Checked %0d results: ok %0d, full %0d, empty/range %0d, not found %0d; %0d errors.",
                 n_results, status_tally[ST_OK], status_tally[ST_FULL],
                 status_tally[ST_EMPTY_RANGE], status_tally[ST_NOT_FOUND], n_errors);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Request driver: hold a stalled request, otherwise advance after a random gap
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        stack_req_t    req;
        stack_result_t pred_res;
        int            send_gap;
        bit            calm_send;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            operation <= OP_PUSH;
            value <= '0;
            position <= '0;
            send_gap = 0;
            calm_send = 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                pred_res = predict_stack_result(operation, value, position);
                expected_results = {expected_results, pred_res};
                op_tally[operation]++;
                n_accepted++;
            end
            // Hold everything while the current request is stalled
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() == 0)
                    in_valid <= 1'b0;
                else if (pending_reqs[0].wait_drain)
                begin
                    in_valid <= 1'b0;
                    if (expected_results.size() == 0)
                    begin
                        void'(pending_reqs.pop_front());
                        n_drains++;
                    end
                end
                else
                begin
                    req = pending_reqs.pop_front();
                    operation <= req.op;
                    value <= req.val;
                    position <= req.pos;
                    in_valid <= 1'b1;
                    send_gap = pick_gap(calm_send);
                    if ($urandom_range(0, 39) == 0)
                        calm_send = !calm_send;
                end
            end
        end
    end

    // Long receiver hold-off so the request queue fills and in_stall rises
    initial
    begin : receiver_hold
        for (int k = 1; k <= 2; k++)
        begin
            while (n_accepted < k * 300)
                @(posedge clk);
            hold_off <= 1'b1;
            repeat (LONG_HOLD) @(posedge clk);
            hold_off <= 1'b0;
        end
    end

    task automatic report_error(string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("ERROR: %s", msg);
    endtask

    // Result monitor: check each accepted result against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        stack_result_t exp_res;
        int            stall_left;
        bit            calm_recv;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
            calm_recv = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                n_results++;
                if (expected_results.size() == 0)
                    report_error($sformatf("result with no request outstanding: status %0d count %0d",
                                           status, count));
                else
                begin
                    exp_res = expected_results.pop_front();
                    status_tally[exp_res.st]++;
                    if (status !== exp_res.st || read_value !== exp_res.rd ||
                        found_index !== exp_res.fidx || count !== exp_res.cnt ||
                        is_empty !== exp_res.empty)
                        report_error($sformatf({"result %0d: expected st %0d rd %h idx %0d cnt %0d ",
                                                "empty %0b, got st %0d rd %h idx %0d cnt %0d empty %0b"},
                                               n_results, exp_res.st, exp_res.rd, exp_res.fidx,
                                               exp_res.cnt, exp_res.empty, status, read_value,
                                               found_index, count, is_empty));
                end
            end
            if (hold_off)
                out_stall <= 1'b1;
            else
            begin
                out_stall <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
                else if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap(calm_recv);
                if ($urandom_range(0, 59) == 0)
                    calm_recv = !calm_recv;
            end
        end
    end

    // Watchdog: end the run if no request or result moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no request or result accepted for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bstk_pkg.sv
rtl/bstk_ram.sv
rtl/bstk_front.sv
rtl/bstk_back.sv
rtl/bounded_stack_with_search_top.sv
test/tb_top.sv
